>>> hdl/udt_pkg.sv
package udt_pkg;

    // Input request: one key-down or pointer-press event
    typedef struct packed {
        logic       kind;
        logic [7:0] key_code;
        logic       shift_held;
        logic       caps_on;
        logic       window_changed;
    } evt_t;

    // Result: what the host should emit for the event
    typedef struct packed {
        logic       pass_key;
        logic       erase_count;
        logic [7:0] first_char;
        logic [7:0] second_char;
    } res_t;

    // Digraph memory carried from one event to the next
    typedef struct packed {
        logic [2:0] undo_mode;
        logic [7:0] last_letter;
        logic       last_upper;
    } state_t;

    // Event kinds
    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_CLICK = 1'b1;

    // Undo modes
    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_A_LO = 3'd1;
    localparam logic [2:0] MODE_A_UP = 3'd2;
    localparam logic [2:0] MODE_O_LO = 3'd3;
    localparam logic [2:0] MODE_O_UP = 3'd4;
    localparam logic [2:0] MODE_U_LO = 3'd5;
    localparam logic [2:0] MODE_U_UP = 3'd6;
    localparam logic [2:0] MODE_SZ   = 3'd7;

    // Virtual key range of letters, and offset to lower-case ASCII
    localparam logic [7:0] VK_LETTER_LO = 8'h41;
    localparam logic [7:0] VK_LETTER_HI = 8'h5A;
    localparam logic [7:0] LOWER_OFFSET = 8'd32;

    // ASCII letters
    localparam logic [7:0] CH_NONE = 8'h00;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_E_LO = 8'h65;
    localparam logic [7:0] CH_E_UP = 8'h45;
    localparam logic [7:0] CH_O_LO = 8'h6F;
    localparam logic [7:0] CH_O_UP = 8'h4F;
    localparam logic [7:0] CH_U_LO = 8'h75;
    localparam logic [7:0] CH_U_UP = 8'h55;
    localparam logic [7:0] CH_S_LO = 8'h73;
    localparam logic [7:0] CH_S_UP = 8'h53;

    // Latin-1 replacement characters
    localparam logic [7:0] L1_AUML_UP = 8'hC4;
    localparam logic [7:0] L1_AUML_LO = 8'hE4;
    localparam logic [7:0] L1_OUML_UP = 8'hD6;
    localparam logic [7:0] L1_OUML_LO = 8'hF6;
    localparam logic [7:0] L1_UUML_UP = 8'hDC;
    localparam logic [7:0] L1_UUML_LO = 8'hFC;
    localparam logic [7:0] L1_SHARP_S = 8'hDF;

endpackage

>>> hdl/udt_step.sv
module udt_step (
    input  logic            enable,
    input  udt_pkg::evt_t   evt,
    input  udt_pkg::state_t state_cur,
    output udt_pkg::res_t   res,
    output udt_pkg::state_t state_next
);
    import udt_pkg::*;

    logic       is_letter;
    logic       up;
    logic [7:0] cur;
    logic [2:0] mode;
    logic [7:0] last;

    // Decode the key
    assign is_letter = (evt.key_code inside {[VK_LETTER_LO:VK_LETTER_HI]});
    assign up        = evt.shift_held ^ evt.caps_on;
    assign cur       = evt.key_code + LOWER_OFFSET;

    // Window change clears the memory before the key is handled
    assign mode = evt.window_changed ? MODE_NONE : state_cur.undo_mode;
    assign last = evt.window_changed ? CH_NONE : state_cur.last_letter;

    // Decide the result and the next memory
    always_comb
    begin
        res.pass_key    = 1'b1;
        res.erase_count = 1'b0;
        res.first_char  = CH_NONE;
        res.second_char = CH_NONE;
        state_next      = state_cur;

        if (enable)
        begin
            if (evt.kind == KIND_CLICK || !is_letter)
            begin
                // drop memory, pass the event
                state_next.undo_mode   = MODE_NONE;
                state_next.last_letter = CH_NONE;
            end
            else if (mode != MODE_NONE && mode != MODE_SZ && cur == CH_E_LO)
            begin
                // undo an umlaut: restore vowel plus retyped e
                res.pass_key    = 1'b0;
                res.erase_count = 1'b1;
                case (mode)
                    MODE_A_LO: res.first_char = CH_A_LO;
                    MODE_A_UP: res.first_char = CH_A_UP;
                    MODE_O_LO: res.first_char = CH_O_LO;
                    MODE_O_UP: res.first_char = CH_O_UP;
                    MODE_U_LO: res.first_char = CH_U_LO;
                    default:   res.first_char = CH_U_UP;
                endcase
                res.second_char        = up ? CH_E_UP : CH_E_LO;
                state_next.undo_mode   = MODE_NONE;
                state_next.last_letter = CH_E_LO;
                state_next.last_upper  = up;
            end
            else if (mode == MODE_SZ && cur == CH_S_LO)
            begin
                // undo sharp s: restore both s letters
                res.pass_key           = 1'b0;
                res.erase_count        = 1'b1;
                res.first_char         = state_cur.last_upper ? CH_S_UP : CH_S_LO;
                res.second_char        = up ? CH_S_UP : CH_S_LO;
                state_next.undo_mode   = MODE_NONE;
                state_next.last_letter = CH_S_LO;
                state_next.last_upper  = up;
            end
            else if (cur == CH_E_LO && (last == CH_A_LO || last == CH_O_LO || last == CH_U_LO))
            begin
                // new umlaut, case from the first letter
                res.pass_key           = 1'b0;
                res.erase_count        = 1'b1;
                state_next.last_letter = CH_NONE;
                if (last == CH_A_LO)
                begin
                    res.first_char       = state_cur.last_upper ? L1_AUML_UP : L1_AUML_LO;
                    state_next.undo_mode = state_cur.last_upper ? MODE_A_UP : MODE_A_LO;
                end
                else if (last == CH_O_LO)
                begin
                    res.first_char       = state_cur.last_upper ? L1_OUML_UP : L1_OUML_LO;
                    state_next.undo_mode = state_cur.last_upper ? MODE_O_UP : MODE_O_LO;
                end
                else
                begin
                    res.first_char       = state_cur.last_upper ? L1_UUML_UP : L1_UUML_LO;
                    state_next.undo_mode = state_cur.last_upper ? MODE_U_UP : MODE_U_LO;
                end
            end
            else if (cur == CH_S_LO && last == CH_S_LO)
            begin
                // new sharp s
                res.pass_key           = 1'b0;
                res.erase_count        = 1'b1;
                res.first_char         = L1_SHARP_S;
                state_next.undo_mode   = MODE_SZ;
                state_next.last_letter = CH_NONE;
            end
            else
            begin
                // plain letter: remember it
                state_next.undo_mode   = MODE_NONE;
                state_next.last_letter = cur;
                state_next.last_upper  = up;
            end
        end
    end

endmodule

>>> hdl/umlaut_digraph_transliterator_core.sv
// Umlaut digraph transliterator.
// Event channel: evt_valid / evt_stall with payload evt (key-down or pointer
// press). Result channel: res_valid / res_stall with payload res, one result
// for every event, in order. A request is taken at a clock edge where valid is
// high and stall is low.
// Configuration: cfg_wr_en / cfg_wr_data write the enable bit (reset 1);
// write it only while no event is in flight.
// Pipeline: an input register, then the single-pass rewrite logic, then the
// result register. res_valid rises once the event has moved from the input
// register into the result register, and the block takes one event per cycle
// while the receiver does not stall; the digraph memory is updated in the same
// cycle that an event moves into the result register, so back-to-back events
// see each other's effect.
// Reset clears both stages, the digraph memory (no letter, no undo pending)
// and sets enable. When the receiver stalls, the result register holds its
// request, the input register fills, and evt_stall rises once both are full.
module umlaut_digraph_transliterator_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            evt_valid,
    output logic            evt_stall,
    input  udt_pkg::evt_t   evt,
    output logic            res_valid,
    input  logic            res_stall,
    output udt_pkg::res_t   res,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data
);
    import udt_pkg::*;

    logic   enable_reg;
    logic   s1_valid_reg;
    logic   s1_valid_next;
    evt_t   s1_evt_reg;
    logic   res_valid_reg;
    logic   res_valid_next;
    res_t   res_reg;
    res_t   res_next;
    state_t state_reg;
    state_t state_next;
    logic   s1_advance;
    logic   evt_take;

    // Move the input stage when the result register is free or draining
    assign s1_advance = !res_valid_reg || !res_stall;
    assign evt_stall  = s1_valid_reg && !s1_advance;
    assign evt_take   = evt_valid && !evt_stall;

    assign s1_valid_next  = evt_take || (s1_valid_reg && !s1_advance);
    assign res_valid_next = s1_advance ? s1_valid_reg : res_valid_reg;

    // Rewrite logic
    udt_step u_step (
        .enable     (enable_reg),
        .evt        (s1_evt_reg),
        .state_cur  (state_reg),
        .res        (res_next),
        .state_next (state_next)
    );

    // Hold the enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b1;
        else if (cfg_wr_en)
            enable_reg <= cfg_wr_data;
    end

    // Advance the pipeline valid bits and the digraph memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '{undo_mode: MODE_NONE, last_letter: CH_NONE, last_upper: 1'b0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_valid_reg && s1_advance)
                state_reg <= state_next;
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (evt_take)
            s1_evt_reg <= evt;
        if (s1_valid_reg && s1_advance)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
